// ===== sv/lfa_pkg.sv =====
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared types and constants for the loopback frame assembler.
// ----------------------------------------------------------------------------
package lfa_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int FILL_BURST      = 64;
    localparam int RESULT_CAP      = 64;
    localparam int JOBQ_DEPTH      = 4;
    localparam int JOBQ_AW         = $clog2(JOBQ_DEPTH);
    localparam int SIZE_W          = 12;
    localparam int LEN_W           = 7;

    typedef enum logic [1:0] {
        CMD_FORWARD = 2'd0,
        CMD_PAYLOAD = 2'd1,
        CMD_CLOSE   = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        PHASE_START  = 2'd0,
        PHASE_HEADER = 2'd1,
        PHASE_REPLY  = 2'd2,
        PHASE_CLOSED = 2'd3
    } phase_e;

    typedef enum logic [1:0] {
        REG_SKIP_COUNT     = 2'd0,
        REG_RECEIPT_NUMBER = 2'd1,
        REG_FILLER_BYTE    = 2'd2,
        REG_FRAME_SIZE     = 2'd3
    } reg_e;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] fwd_address;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic [10:0] byte_offset;
        logic        run_last;
        logic        frame_end;
    } out_item_t;

    typedef struct packed {
        logic             hdr;
        logic             fwd;
        logic             rep;
        logic             pay;
        logic [LEN_W-1:0] len;
        logic [47:0]      fwd_address;
        logic [7:0]       payload_byte;
    } job_t;

    typedef struct packed {
        logic [15:0]       skip_count;
        logic [15:0]       receipt_number;
        logic [7:0]        filler_byte;
        logic [SIZE_W-1:0] frame_size;
    } cfg_t;

endpackage

// ===== sv/loopback_frame_assembler.sv =====
// ----------------------------------------------------------------------------
// loopback_frame_assembler
// Builds a loopback frame as a byte stream cut to the configured size.
// The first byte of an item passes through the job queue and then the output
// register before it reaches the result ports.
// Throughput: one frame byte per cycle from the back end while the result
// side is free; an item's job lists up to ten bytes, or up to 64 for a close,
// an item whose bytes all fall beyond the frame size yields nothing and one
// that yields no bytes makes no job, and items are taken every cycle while
// the four-entry job queue has room.
// Reset clears the frame position, the phase, the job queue and the output
// valid flag; it zeroes the configuration registers but sets the size to 64.
// ----------------------------------------------------------------------------
module loopback_frame_assembler
    import lfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic      pready,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    cfg_t cfg_reg;
    logic cfg_wr;
    logic job_push;
    job_t job_in;
    logic job_full;
    logic job_valid;
    job_t job_head;
    logic job_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_count     <= '0;
            cfg_reg.receipt_number <= '0;
            cfg_reg.filler_byte    <= '0;
            cfg_reg.frame_size     <= SIZE_W'(64);
        end
        else if (cfg_wr)
        begin
            case (reg_e'(paddr[3:2]))
                REG_SKIP_COUNT:     cfg_reg.skip_count     <= pwdata[15:0];
                REG_RECEIPT_NUMBER: cfg_reg.receipt_number <= pwdata[15:0];
                REG_FILLER_BYTE:    cfg_reg.filler_byte    <= pwdata[7:0];
                REG_FRAME_SIZE:     cfg_reg.frame_size     <= pwdata[SIZE_W-1:0];
                default:            cfg_reg.frame_size     <= cfg_reg.frame_size;
            endcase
        end
    end

    always_comb
    begin
        case (reg_e'(paddr[3:2]))
            REG_SKIP_COUNT:     prdata = {16'd0, cfg_reg.skip_count};
            REG_RECEIPT_NUMBER: prdata = {16'd0, cfg_reg.receipt_number};
            REG_FILLER_BYTE:    prdata = {24'd0, cfg_reg.filler_byte};
            REG_FRAME_SIZE:     prdata = {{(32 - SIZE_W){1'b0}}, cfg_reg.frame_size};
            default:            prdata = '0;
        endcase
    end

    lfa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    lfa_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (job_in),
        .full     (job_full),
        .rd_en    (job_pop),
        .rd_job   (job_head),
        .rd_valid (job_valid)
    );

    lfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== sv/lfa_front.sv =====
// ----------------------------------------------------------------------------
// lfa_front
// Accepts input items, tracks the frame phase and turns each item into a
// job that lists the byte segments it produces.
// ----------------------------------------------------------------------------
module lfa_front
    import lfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     job_push,
    output job_t     job,
    input  logic     job_full
);

    phase_e phase_reg;
    phase_e phase_next;
    phase_e phase_mid;
    logic   accept;
    logic   [LEN_W-1:0] fixed_len;
    logic   [LEN_W-1:0] fill_len;

    assign full   = job_full;
    assign accept = push && !job_full;

    always_comb
    begin
        job.hdr          = 1'b0;
        job.fwd          = 1'b0;
        job.rep          = 1'b0;
        job.pay          = 1'b0;
        job.fwd_address  = item.fwd_address;
        job.payload_byte = item.payload_byte;
        phase_next       = phase_reg;
        phase_mid        = (phase_reg == PHASE_START) ? PHASE_HEADER : phase_reg;
        case (cmd_e'(item.cmd))
            CMD_FORWARD:
            begin
                job.hdr    = (phase_reg == PHASE_START);
                job.fwd    = (phase_mid == PHASE_HEADER);
                phase_next = phase_mid;
            end
            CMD_PAYLOAD:
            begin
                job.hdr    = (phase_reg == PHASE_START);
                job.rep    = (phase_mid == PHASE_HEADER);
                job.pay    = job.rep || (phase_mid == PHASE_REPLY);
                phase_next = job.rep ? PHASE_REPLY : phase_mid;
            end
            CMD_CLOSE:
            begin
                job.hdr    = (phase_reg == PHASE_START);
                job.rep    = (phase_mid == PHASE_HEADER);
                phase_next = PHASE_CLOSED;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
        fixed_len = (job.hdr ? LEN_W'(2) : '0) + (job.fwd ? LEN_W'(8) : '0)
                  + (job.rep ? LEN_W'(4) : '0) + (job.pay ? LEN_W'(1) : '0);
        if (fixed_len + LEN_W'(FILL_BURST) > LEN_W'(RESULT_CAP))
        begin
            fill_len = LEN_W'(RESULT_CAP);
        end
        else
        begin
            fill_len = fixed_len + LEN_W'(FILL_BURST);
        end
        job.len  = (cmd_e'(item.cmd) == CMD_CLOSE) ? fill_len : fixed_len;
        job_push = accept && (job.len != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_START;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    // A job with a payload byte only leaves when the item moves the frame to the reply phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push && job.pay |-> phase_next == PHASE_REPLY)
        else $error("payload job outside the reply phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push && job.fwd |-> phase_reg != PHASE_REPLY && phase_reg != PHASE_CLOSED)
        else $error("forward job after the reply header");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PHASE_CLOSED |=> phase_reg == PHASE_CLOSED)
        else $error("closed frame left its final phase");

endmodule

// ===== sv/lfa_job_queue.sv =====
// ----------------------------------------------------------------------------
// lfa_job_queue
// Short queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module lfa_job_queue
    import lfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic rd_valid
);

    job_t                 entry_reg [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0]   wr_ptr_reg;
    logic [JOBQ_AW-1:0]   rd_ptr_reg;
    logic [JOBQ_AW:0]     count_reg;
    logic [JOBQ_AW:0]     count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (count_reg == (JOBQ_AW + 1)'(JOBQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (JOBQ_AW + 1)'(JOBQ_DEPTH))
        else $error("job queue count above its depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + 1'b1)
        else $error("job queue count missed a write");
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid |-> rd_job.len != '0)
        else $error("empty job in the queue");

endmodule

// ===== sv/lfa_back.sv =====
// ----------------------------------------------------------------------------
// lfa_back
// Walks each job one byte per cycle while the output is free, keeps the frame
// position, drops bytes beyond the frame size and registers the result.
// ----------------------------------------------------------------------------
module lfa_back
    import lfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic [SIZE_W-1:0] pos_reg;
    logic [SIZE_W-1:0] pos_next;
    logic [LEN_W-2:0]  idx_reg;
    logic [LEN_W-2:0]  idx_next;
    out_item_t         out_reg;
    logic              out_valid_reg;
    logic [SIZE_W-1:0] size_eff;
    logic              can_out;
    logic              room;
    logic              emit;
    logic              last;
    logic [LEN_W-1:0]  k;
    logic [LEN_W-1:0]  seg_a;
    logic [LEN_W-1:0]  seg_b;
    logic [LEN_W-1:0]  seg_c;
    logic [LEN_W-1:0]  seg_d;
    logic [LEN_W-1:0]  rel;
    logic [7:0]        cur_byte;

    assign size_eff = (cfg.frame_size > SIZE_W'(MAX_FRAME_BYTES))
                    ? SIZE_W'(MAX_FRAME_BYTES) : cfg.frame_size;
    assign can_out  = !out_valid_reg || pop;
    assign room     = (pos_reg < size_eff);
    assign emit     = job_valid && can_out && room;
    assign k        = {1'b0, idx_reg};
    assign last     = (k + 1'b1 == job.len) || (pos_reg + 1'b1 == size_eff);
    assign job_pop  = job_valid && can_out && (!room || last);
    assign pos_next = emit ? pos_reg + 1'b1 : pos_reg;
    assign idx_next = job_pop ? '0 : (emit ? idx_reg + 1'b1 : idx_reg);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    assign seg_a = job.hdr ? LEN_W'(2) : '0;
    assign seg_b = seg_a + (job.fwd ? LEN_W'(8) : '0);
    assign seg_c = seg_b + (job.rep ? LEN_W'(4) : '0);
    assign seg_d = seg_c + (job.pay ? LEN_W'(1) : '0);

    always_comb
    begin
        rel      = '0;
        cur_byte = cfg.filler_byte;
        if (k < seg_a)
        begin
            cur_byte = k[0] ? cfg.skip_count[15:8] : cfg.skip_count[7:0];
        end
        else if (k < seg_b)
        begin
            rel = k - seg_a;
            case (rel[2:0])
                3'd0:    cur_byte = 8'd2;
                3'd1:    cur_byte = 8'd0;
                3'd2:    cur_byte = job.fwd_address[47:40];
                3'd3:    cur_byte = job.fwd_address[39:32];
                3'd4:    cur_byte = job.fwd_address[31:24];
                3'd5:    cur_byte = job.fwd_address[23:16];
                3'd6:    cur_byte = job.fwd_address[15:8];
                default: cur_byte = job.fwd_address[7:0];
            endcase
        end
        else if (k < seg_c)
        begin
            rel = k - seg_b;
            case (rel[1:0])
                2'd0:    cur_byte = 8'd1;
                2'd1:    cur_byte = 8'd0;
                2'd2:    cur_byte = cfg.receipt_number[7:0];
                default: cur_byte = cfg.receipt_number[15:8];
            endcase
        end
        else if (k < seg_d)
        begin
            cur_byte = job.payload_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            idx_reg <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.frame_byte  <= cur_byte;
            out_reg.byte_offset <= pos_reg[10:0];
            out_reg.run_last    <= last;
            out_reg.frame_end   <= (pos_reg + 1'b1 == size_eff);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= SIZE_W'(MAX_FRAME_BYTES))
        else $error("frame position beyond the largest frame");
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && (pos_reg + 1'b1 == size_eff) |-> job_pop)
        else $error("job kept going past the frame end");
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(out_reg) && !empty)
        else $error("waiting result changed before it was taken");

endmodule
